// File: hdl/hra_pkg.sv
// Householder reflection engine: shared types, codes and default constants.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
// No dependencies.
package hra_pkg;

    // Default sizing (overridable on the top level)
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 3;
    localparam int CNT_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_WR_MAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_VEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_START = 3'd4;

    // Reflection modes
    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINE,
        ST_DOT,
        ST_TWAIT,
        ST_UPD,
        ST_UWAIT,
        ST_EMIT,
        ST_EDRAIN
    } hra_state_t;

    // Datapath operation of an issued element
    typedef enum logic {
        OP_DOT,
        OP_UPD
    } hra_op_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic    issue;
        hra_op_t op;
        logic    acc_clr;
        logic    t_load;
        logic    sat_clr;
    } hra_dp_ctl_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic busy;
        logic sat;
    } hra_dp_sts_t;

endpackage

// File: hdl/hra_if.sv
// Request and result channel interfaces of the Householder reflection engine.
// Depends on hra_pkg for field widths.
interface hra_req_if;
    logic                              valid;
    logic                              ready;
    logic [hra_pkg::CMD_W-1:0]         cmd;
    logic [hra_pkg::POS_W-1:0]         row;
    logic [hra_pkg::POS_W-1:0]         col;
    logic [hra_pkg::POS_W-1:0]         vec_index;
    logic signed [hra_pkg::VAL_W-1:0]  value;

    modport source (output valid, cmd, row, col, vec_index, value, input ready);
    modport sink (input valid, cmd, row, col, vec_index, value, output ready);
endinterface

interface hra_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [hra_pkg::POS_W-1:0]         out_row;
    logic [hra_pkg::POS_W-1:0]         out_col;
    logic signed [hra_pkg::VAL_W-1:0]  out_value;
    logic                              last;
    logic                              saturated;

    modport source (output valid, out_row, out_col, out_value, last, saturated,
                    input ready);
    modport sink (input valid, out_row, out_col, out_value, last, saturated,
                  output ready);
endinterface

// File: hdl/hra_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered, enable-held read output. No dependencies.
module hra_ram #(
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic             re,
    input  logic [AW-1:0]    ra,
    output logic [WIDTH-1:0] rd
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Read port, output holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    assign rd = rd_reg;

endmodule

// File: hdl/hra_datapath.sv
// Multiply, round, accumulate and update pipeline of the reflection engine.
// Stage 1 takes the RAM read data and multiplies, stage 2 rounds and either
// accumulates the dot product or writes back the updated element.
// Depends on hra_pkg.
module hra_datapath #(
    parameter int MAX_DIM   = hra_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = hra_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hra_pkg::hra_dp_ctl_t             ctl,
    input  logic [2*$clog2(MAX_DIM)-1:0]     issue_addr,
    input  logic signed [hra_pkg::VAL_W-1:0] mat_rd,
    input  logic signed [hra_pkg::VAL_W-1:0] vec_rd,
    output logic                             wr_en,
    output logic [2*$clog2(MAX_DIM)-1:0]     wr_addr,
    output logic signed [hra_pkg::VAL_W-1:0] wr_data,
    output hra_pkg::hra_dp_sts_t             sts
);

    localparam int AW   = 2 * $clog2(MAX_DIM);
    localparam int VW   = hra_pkg::VAL_W;
    localparam int PW   = 2 * hra_pkg::VAL_W;
    localparam logic signed [PW-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] SAT_MAX    = 64'sd2147483647;
    localparam logic signed [PW-1:0] SAT_MIN    = -64'sd2147483648;
    localparam logic signed [PW-1:0] HALF_MAX   = 64'sd1073741824;

    // Stage 1 registers (RAM data valid in this stage)
    logic                   s1_valid_reg;
    hra_pkg::hra_op_t       s1_op_reg;
    logic [AW-1:0]          s1_addr_reg;

    // Stage 2 registers
    logic                   s2_valid_reg;
    hra_pkg::hra_op_t       s2_op_reg;
    logic [AW-1:0]          s2_addr_reg;
    logic signed [VW-1:0]   s2_m_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;

    // Accumulator, reflection scale and saturation flag
    logic signed [PW-1:0]   acc_reg;
    logic signed [VW-1:0]   t_reg;
    logic signed [VW-1:0]   t_next;
    logic                   t_sat;
    logic                   sat_reg;

    logic signed [VW-1:0]   mul_a;
    logic signed [PW-1:0]   rounded;
    logic signed [PW-1:0]   diff;
    logic                   diff_hi;
    logic                   diff_lo;
    logic                   upd_valid;

    // Stage 1: multiplier operand select and product
    always_comb
    begin
        mul_a     = (s1_op_reg == hra_pkg::OP_DOT) ? mat_rd : t_reg;
        prod_next = mul_a * vec_rd;
    end

    // Stage 2: round half up, subtract and saturate
    always_comb
    begin
        rounded   = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
        diff      = {{VW{s2_m_reg[VW-1]}}, s2_m_reg} - rounded;
        diff_hi   = diff > SAT_MAX;
        diff_lo   = diff < SAT_MIN;
        upd_valid = s2_valid_reg && (s2_op_reg == hra_pkg::OP_UPD);
        if (diff_hi)
        begin
            wr_data = SAT_MAX[VW-1:0];
        end
        else if (diff_lo)
        begin
            wr_data = SAT_MIN[VW-1:0];
        end
        else
        begin
            wr_data = diff[VW-1:0];
        end
    end

    // t = 2 * acc, saturated to 32 bits
    always_comb
    begin
        if (acc_reg >= HALF_MAX)
        begin
            t_next = SAT_MAX[VW-1:0];
            t_sat  = 1'b1;
        end
        else if (acc_reg < -HALF_MAX)
        begin
            t_next = SAT_MIN[VW-1:0];
            t_sat  = 1'b1;
        end
        else
        begin
            t_next = {acc_reg[VW-2:0], 1'b0};
            t_sat  = 1'b0;
        end
    end

    assign wr_en    = upd_valid;
    assign wr_addr  = s2_addr_reg;
    assign sts.busy = s1_valid_reg | s2_valid_reg;
    assign sts.sat  = sat_reg;

    // Pipeline valid bits and saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
            if (ctl.sat_clr)
            begin
                sat_reg <= 1'b0;
            end
            else if ((ctl.t_load && t_sat) || (upd_valid && (diff_hi || diff_lo)))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= ctl.op;
        s1_addr_reg <= issue_addr;
        s2_op_reg   <= s1_op_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_m_reg    <= mat_rd;
        prod_reg    <= prod_next;
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg && (s2_op_reg == hra_pkg::OP_DOT))
        begin
            acc_reg <= acc_reg + rounded;
        end
        if (ctl.t_load)
        begin
            t_reg <= t_next;
        end
    end

endmodule

// File: hdl/hra_ctrl.sv
// Sequencer of the reflection engine: configuration registers, request
// decode, pass/line/element loops, RAM addressing and the result register.
// Depends on hra_pkg and the channel interfaces in hra_if.
module hra_ctrl #(
    parameter int MAX_DIM = hra_pkg::MAX_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [hra_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hra_pkg::CFG_DATA_W-1:0]        cfg_data,
    hra_req_if.sink                               req,
    hra_rsp_if.source                             rsp,
    output logic                                  ld_we,
    output logic [2*$clog2(MAX_DIM)-1:0]          ld_wa,
    output logic                                  mat_re,
    output logic [2*$clog2(MAX_DIM)-1:0]          mat_ra,
    input  logic signed [hra_pkg::VAL_W-1:0]      mat_rd,
    output logic                                  vec_we,
    output logic [$clog2(MAX_DIM)-1:0]            vec_wa,
    output logic                                  vec_re,
    output logic [$clog2(MAX_DIM)-1:0]            vec_ra,
    output hra_pkg::hra_dp_ctl_t                  dp_ctl,
    input  hra_pkg::hra_dp_sts_t                  dp_sts
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = hra_pkg::CNT_W;
    localparam logic [CW-1:0] DIM_MAX = CW'(MAX_DIM);

    // Configuration registers
    logic [CW-1:0]                  row_count_reg;
    logic [CW-1:0]                  col_count_reg;
    logic [hra_pkg::MODE_W-1:0]     reflect_mode_reg;
    logic [hra_pkg::POS_W-1:0]      first_index_reg;
    logic [hra_pkg::POS_W-1:0]      reflect_start_reg;

    // Sequencer state
    hra_pkg::hra_state_t state_reg, state_next;
    logic                is_right_reg, is_right_next;
    logic [CW-1:0]       line_reg, line_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       er_reg, er_next;
    logic [CW-1:0]       ec_reg, ec_next;

    // Read-data tag and result register
    logic                rd_valid_reg, rd_valid_next;
    logic [hra_pkg::POS_W-1:0] rd_row_reg;
    logic [hra_pkg::POS_W-1:0] rd_col_reg;
    logic                rd_last_reg;
    logic                out_valid_reg;
    logic [hra_pkg::POS_W-1:0] out_row_reg;
    logic [hra_pkg::POS_W-1:0] out_col_reg;
    logic signed [hra_pkg::VAL_W-1:0] out_value_reg;
    logic                out_last_reg;
    logic                out_sat_reg;

    logic [CW-1:0]       rows;
    logic [CW-1:0]       cols;
    logic [CW-1:0]       line_lim;
    logic [CW-1:0]       k_lim;
    logic [CW-1:0]       k_start;
    logic                line_go;
    logic                pass_more;
    logic                k_last;
    logic                e_last;
    logic                accept;
    logic                run_start;
    logic                issue;
    logic                emit_issue;
    logic                rd_load;

    function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] c);
        logic [CW-1:0] r;
        r = c;
        if (c == '0)
        begin
            r = CW'(1);
        end
        else if (c > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    // Loop limits and conditions
    always_comb
    begin
        rows      = clamp_count(row_count_reg);
        cols      = clamp_count(col_count_reg);
        line_lim  = is_right_reg ? rows : cols;
        k_lim     = is_right_reg ? cols : rows;
        k_start   = {1'b0, reflect_start_reg};
        line_go   = (line_reg < line_lim) && (k_start < k_lim);
        pass_more = !is_right_reg && (reflect_mode_reg != hra_pkg::MODE_LEFT);
        k_last    = (k_reg == (k_lim - CW'(1)));
        e_last    = (er_reg == (rows - CW'(1))) && (ec_reg == (cols - CW'(1)));
        accept    = req.valid && req.ready;
        run_start = accept && (req.cmd == hra_pkg::CMD_RUN);
        rd_load   = rd_valid_reg && (!out_valid_reg || rsp.ready);
        issue     = (state_reg == hra_pkg::ST_DOT) || (state_reg == hra_pkg::ST_UPD);
        emit_issue = (state_reg == hra_pkg::ST_EMIT) && (!rd_valid_reg || rd_load);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hra_pkg::ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = hra_pkg::ST_LINE;
                end
            end
            hra_pkg::ST_LINE:
            begin
                if (line_go)
                begin
                    state_next = hra_pkg::ST_DOT;
                end
                else if (!pass_more)
                begin
                    state_next = hra_pkg::ST_EMIT;
                end
            end
            hra_pkg::ST_DOT:
            begin
                if (k_last)
                begin
                    state_next = hra_pkg::ST_TWAIT;
                end
            end
            hra_pkg::ST_TWAIT:
            begin
                if (!dp_sts.busy)
                begin
                    state_next = hra_pkg::ST_UPD;
                end
            end
            hra_pkg::ST_UPD:
            begin
                if (k_last)
                begin
                    state_next = hra_pkg::ST_UWAIT;
                end
            end
            hra_pkg::ST_UWAIT:
            begin
                if (!dp_sts.busy)
                begin
                    state_next = hra_pkg::ST_LINE;
                end
            end
            hra_pkg::ST_EMIT:
            begin
                if (emit_issue && e_last)
                begin
                    state_next = hra_pkg::ST_EDRAIN;
                end
            end
            hra_pkg::ST_EDRAIN:
            begin
                if (!rd_valid_reg)
                begin
                    state_next = hra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hra_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and loop counters
    always_comb
    begin
        is_right_next = is_right_reg;
        line_next     = line_reg;
        k_next        = k_reg;
        er_next       = er_reg;
        ec_next       = ec_reg;
        rd_valid_next = rd_valid_reg;

        req.ready = (state_reg == hra_pkg::ST_IDLE);

        // Element loads
        ld_we  = accept && (req.cmd == hra_pkg::CMD_WR_MAT)
                 && ({1'b0, req.row} < DIM_MAX) && ({1'b0, req.col} < DIM_MAX);
        ld_wa  = {req.row[IW-1:0], req.col[IW-1:0]};
        vec_we = accept && (req.cmd == hra_pkg::CMD_WR_VEC)
                 && ({1'b0, req.vec_index} < DIM_MAX);
        vec_wa = req.vec_index[IW-1:0];

        // RAM reads: compute elements or emitted elements
        mat_re = issue || emit_issue;
        if (state_reg == hra_pkg::ST_EMIT || state_reg == hra_pkg::ST_EDRAIN)
        begin
            mat_ra = {er_reg[IW-1:0], ec_reg[IW-1:0]};
        end
        else if (is_right_reg)
        begin
            mat_ra = {line_reg[IW-1:0], k_reg[IW-1:0]};
        end
        else
        begin
            mat_ra = {k_reg[IW-1:0], line_reg[IW-1:0]};
        end
        vec_re = issue;
        vec_ra = k_reg[IW-1:0];

        dp_ctl.issue   = issue;
        dp_ctl.op      = (state_reg == hra_pkg::ST_UPD) ? hra_pkg::OP_UPD : hra_pkg::OP_DOT;
        dp_ctl.acc_clr = (state_reg == hra_pkg::ST_LINE) && line_go;
        dp_ctl.t_load  = (state_reg == hra_pkg::ST_TWAIT) && !dp_sts.busy;
        dp_ctl.sat_clr = run_start;

        // Run start: first pass, first line, emit counters
        if (run_start)
        begin
            is_right_next = (reflect_mode_reg == hra_pkg::MODE_RIGHT);
            line_next     = {1'b0, first_index_reg};
            er_next       = '0;
            ec_next       = '0;
        end

        // Line start: element loop start, or pass switch from left to right
        if (state_reg == hra_pkg::ST_LINE)
        begin
            if (line_go)
            begin
                k_next = k_start;
            end
            else if (pass_more)
            begin
                is_right_next = 1'b1;
                line_next     = {1'b0, first_index_reg};
            end
        end

        // Element loops
        if (state_reg == hra_pkg::ST_DOT)
        begin
            k_next = k_last ? k_start : (k_reg + CW'(1));
        end
        if (state_reg == hra_pkg::ST_UPD)
        begin
            k_next = k_reg + CW'(1);
        end
        if ((state_reg == hra_pkg::ST_UWAIT) && !dp_sts.busy)
        begin
            line_next = line_reg + CW'(1);
        end

        // Emit scan
        if (emit_issue)
        begin
            if (ec_reg == (cols - CW'(1)))
            begin
                ec_next = '0;
                er_next = er_reg + CW'(1);
            end
            else
            begin
                ec_next = ec_reg + CW'(1);
            end
        end
        if (emit_issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (rd_load)
        begin
            rd_valid_next = 1'b0;
        end

        rsp.valid     = out_valid_reg;
        rsp.out_row   = out_row_reg;
        rsp.out_col   = out_col_reg;
        rsp.out_value = out_value_reg;
        rsp.last      = out_last_reg;
        rsp.saturated = out_sat_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= CW'(8);
            col_count_reg     <= CW'(8);
            reflect_mode_reg  <= hra_pkg::MODE_BOTH;
            first_index_reg   <= '0;
            reflect_start_reg <= '0;
            state_reg         <= hra_pkg::ST_IDLE;
            is_right_reg      <= 1'b0;
            line_reg          <= '0;
            k_reg             <= '0;
            er_reg            <= '0;
            ec_reg            <= '0;
            rd_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    hra_pkg::CFG_ROW_COUNT:     row_count_reg     <= cfg_data;
                    hra_pkg::CFG_COL_COUNT:     col_count_reg     <= cfg_data;
                    hra_pkg::CFG_REFLECT_MODE:  reflect_mode_reg  <= cfg_data[hra_pkg::MODE_W-1:0];
                    hra_pkg::CFG_FIRST_INDEX:   first_index_reg   <= cfg_data[hra_pkg::POS_W-1:0];
                    hra_pkg::CFG_REFLECT_START: reflect_start_reg <= cfg_data[hra_pkg::POS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg    <= state_next;
            is_right_reg <= is_right_next;
            line_reg     <= line_next;
            k_reg        <= k_next;
            er_reg       <= er_next;
            ec_reg       <= ec_next;
            rd_valid_reg <= rd_valid_next;
            if (rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read tags and result payload
    always_ff @(posedge clk)
    begin
        if (emit_issue)
        begin
            rd_row_reg  <= er_reg[hra_pkg::POS_W-1:0];
            rd_col_reg  <= ec_reg[hra_pkg::POS_W-1:0];
            rd_last_reg <= e_last;
        end
        if (rd_load)
        begin
            out_row_reg   <= rd_row_reg;
            out_col_reg   <= rd_col_reg;
            out_value_reg <= mat_rd;
            out_last_reg  <= rd_last_reg;
            out_sat_reg   <= dp_sts.sat;
        end
    end

endmodule

// File: hdl/householder_reflection_apply.sv
// Householder reflection engine, top level: matrix and vector RAMs, the
// sequencer and the multiply/update datapath.
// Depends on hra_pkg, hra_if, hra_ram, hra_datapath and hra_ctrl.
//
// Usage: requests arrive on req (valid/ready). cmd write-matrix and
// write-vector store one element each; they give no result. cmd run applies
// I - 2vv^T (left pass, right pass or both, per reflect_mode) to the stored
// matrix, then emits row_count x col_count results row-major on rsp, last
// set on the final one, saturated set on all of them if any value of the run
// clipped. The user must write registers through cfg_wr_en/cfg_index/cfg_data
// only while no run is in progress; the block does not enforce it.
// Timing: for each updated line of K active elements, a run makes one matrix
// RAM read per cycle for the dot product, drains the multiply pipeline, makes
// one read-modify-write per cycle for the update and drains it again, then
// emits one result per cycle while rsp.ready is high.
// The single matrix read port sets that rate. req.ready is high only between
// runs. A stalled rsp holds its result; the next element waits in the RAM
// read register, so nothing is lost. Reset returns the registers to their
// defaults and the sequencer to idle; RAM contents are undefined until written.
module householder_reflection_apply #(
    parameter int MAX_DIM   = hra_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = hra_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hra_req_if.sink                         req,
    hra_rsp_if.source                       rsp,
    input  logic                            cfg_wr_en,
    input  logic [hra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hra_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;
    localparam int VW = hra_pkg::VAL_W;

    logic                  ld_we;
    logic [AW-1:0]         ld_wa;
    logic                  up_we;
    logic [AW-1:0]         up_wa;
    logic signed [VW-1:0]  up_wd;
    logic                  mat_we;
    logic [AW-1:0]         mat_wa;
    logic signed [VW-1:0]  mat_wd;
    logic                  mat_re;
    logic [AW-1:0]         mat_ra;
    logic signed [VW-1:0]  mat_rd;
    logic                  vec_we;
    logic [IW-1:0]         vec_wa;
    logic                  vec_re;
    logic [IW-1:0]         vec_ra;
    logic signed [VW-1:0]  vec_rd;
    hra_pkg::hra_dp_ctl_t  dp_ctl;
    hra_pkg::hra_dp_sts_t  dp_sts;

    // Matrix write port: element loads between runs, updates during a run
    always_comb
    begin
        mat_we = ld_we | up_we;
        mat_wa = up_we ? up_wa : ld_wa;
        mat_wd = up_we ? up_wd : req.value;
    end

    hra_ram #(
        .WIDTH (VW),
        .AW    (AW)
    ) u_mat_ram (
        .clk (clk),
        .we  (mat_we),
        .wa  (mat_wa),
        .wd  (mat_wd),
        .re  (mat_re),
        .ra  (mat_ra),
        .rd  (mat_rd)
    );

    hra_ram #(
        .WIDTH (VW),
        .AW    (IW)
    ) u_vec_ram (
        .clk (clk),
        .we  (vec_we),
        .wa  (vec_wa),
        .wd  (req.value),
        .re  (vec_re),
        .ra  (vec_ra),
        .rd  (vec_rd)
    );

    hra_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .ld_we     (ld_we),
        .ld_wa     (ld_wa),
        .mat_re    (mat_re),
        .mat_ra    (mat_ra),
        .mat_rd    (mat_rd),
        .vec_we    (vec_we),
        .vec_wa    (vec_wa),
        .vec_re    (vec_re),
        .vec_ra    (vec_ra),
        .dp_ctl    (dp_ctl),
        .dp_sts    (dp_sts)
    );

    hra_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (dp_ctl),
        .issue_addr (mat_ra),
        .mat_rd     (mat_rd),
        .vec_rd     (vec_rd),
        .wr_en      (up_we),
        .wr_addr    (up_wa),
        .wr_data    (up_wd),
        .sts        (dp_sts)
    );

endmodule
